// ----- src/slr_pkg.sv -----
// Package for the state line receiver: sizes, status codes, text constants
// and the character lookup functions shared by the top level and the matcher.
// Depends on nothing.
package slr_pkg;

    localparam int LINE_CAPACITY = 64;
    localparam int FILL_W = $clog2(LINE_CAPACITY + 1);
    localparam int ADDR_W = $clog2(LINE_CAPACITY);

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN = 8'd13;

    localparam logic [1:0] STATUS_VALID = 2'd0;
    localparam logic [1:0] STATUS_MALFORMED = 2'd1;
    localparam logic [1:0] STATUS_OVERSIZED = 2'd2;

    localparam int HEAD_LEN = 14;
    localparam int WORD_COUNT = 6;
    localparam int MAX_WORD = 17;

    localparam logic [8*HEAD_LEN-1:0] HEAD_TEXT = "PANEL 1 STATE ";

    localparam logic [8*MAX_WORD-1:0] WORD_TEXT [WORD_COUNT] = '{
        "starting", "ready", "hotspot_waiting", "hotspot_connected", "fault", "off"
    };

    localparam int WORD_LEN [WORD_COUNT] = '{8, 5, 15, 17, 5, 3};

    typedef struct packed {
        logic clear;
        logic step;
    } match_cmd_t;

    typedef struct packed {
        logic       matched;
        logic [2:0] code;
    } match_res_t;

    function automatic logic [7:0] head_char(input logic [ADDR_W-1:0] idx);
        int i;
        logic [7:0] ch;
        i = int'(idx);
        ch = 8'd0;
        if (i < HEAD_LEN)
        begin
            ch = HEAD_TEXT[8*(HEAD_LEN-1-i) +: 8];
        end
        return ch;
    endfunction

    function automatic logic [7:0] word_char(input int w, input int i);
        logic [7:0] ch;
        ch = 8'd0;
        if (i >= 0 && i < WORD_LEN[w])
        begin
            ch = WORD_TEXT[w][8*(WORD_LEN[w]-1-i) +: 8];
        end
        return ch;
    endfunction

    function automatic logic len_legal(input logic [FILL_W-1:0] len);
        logic ok;
        ok = 1'b0;
        for (int w = 0; w < WORD_COUNT; w++)
        begin
            if (int'(len) == HEAD_LEN + WORD_LEN[w])
            begin
                ok = 1'b1;
            end
        end
        return ok;
    endfunction

endpackage

// ----- src/slr_matcher.sv -----
// Per-word match tracker: one flag per state word, narrowed one stored
// character at a time while the line is read back. Depends on slr_pkg.
module slr_matcher (
    input  logic                     clk,
    input  slr_pkg::match_cmd_t      cmd,
    input  logic [slr_pkg::FILL_W-1:0] len,
    input  logic [slr_pkg::ADDR_W-1:0] pos,
    input  logic [7:0]               data,
    output slr_pkg::match_res_t      res
);
    import slr_pkg::*;

    logic [WORD_COUNT-1:0] flag_reg;
    logic [WORD_COUNT-1:0] flag_next;

    always_comb
    begin
        flag_next = flag_reg;
        if (cmd.clear)
        begin
            for (int w = 0; w < WORD_COUNT; w++)
            begin
                flag_next[w] = (int'(len) == HEAD_LEN + WORD_LEN[w]);
            end
        end
        else if (cmd.step)
        begin
            for (int w = 0; w < WORD_COUNT; w++)
            begin
                if (int'(pos) < HEAD_LEN)
                begin
                    flag_next[w] = flag_reg[w] & (data == head_char(pos));
                end
                else
                begin
                    flag_next[w] = flag_reg[w] &
                                   (data == word_char(w, int'(pos) - HEAD_LEN));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        flag_reg <= flag_next;
    end

    always_comb
    begin
        res.matched = |flag_reg;
        res.code = 3'd0;
        for (int w = WORD_COUNT - 1; w >= 0; w--)
        begin
            if (flag_reg[w])
            begin
                res.code = 3'(w);
            end
        end
    end

endmodule

// ----- src/state_line_receiver_unit.sv -----
// Top level of the state line receiver: line memory, control sequencer and
// output register. Depends on slr_pkg and slr_matcher.
//
// The input channel carries one received byte per word (rx_byte, in_valid,
// in_stall); the output channel carries one result word per newline
// (line_status, display_state, out_valid, out_stall).
// A byte other than newline is taken and written to the line memory unless
// the line is over capacity; it gives no result. A newline starts a check:
// a read of the last stored byte strips a carriage return, then, when the
// length fits a state word, the stored line is read back one byte per cycle
// through the single read port of the line memory. A newline that ends an
// oversized line skips the check and reports it as oversized. in_stall is
// high during the check. The result waits in an output register; a stalled
// result holds, and the next bytes are still taken meanwhile. A following
// newline waits at the end of its check until the output register is free.
// Reset clears the fill count, the discard flag and the output valid; the
// line memory is not cleared.
module state_line_receiver_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] rx_byte,
    input  logic       in_valid,
    output logic       in_stall,
    output logic [1:0] line_status,
    output logic [2:0] display_state,
    output logic       out_valid,
    input  logic       out_stall
);
    import slr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LAST = 2'd1;
    localparam logic [1:0] S_CMP = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [7:0] line_mem [LINE_CAPACITY];
    logic [7:0] rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic       wr_en;

    logic [1:0] state_reg, state_next;
    logic [FILL_W-1:0] fill_count_reg, fill_count_next;
    logic       discarding_reg, discarding_next;
    logic [FILL_W-1:0] len_reg, len_next;
    logic [ADDR_W-1:0] cmp_pos_reg, cmp_pos_next;
    logic [1:0] done_status_reg, done_status_next;
    logic       done_cmp_reg, done_cmp_next;
    logic       out_valid_reg, out_valid_next;
    logic [1:0] line_status_reg, line_status_next;
    logic [2:0] display_state_reg, display_state_next;

    logic       accept;
    logic [FILL_W-1:0] fill_minus;
    logic [FILL_W-1:0] last_len;
    match_cmd_t cmd;
    match_res_t res;

    assign in_stall = (state_reg != S_IDLE);
    assign accept = in_valid & ~in_stall;
    assign fill_minus = fill_count_reg - FILL_W'(1);
    assign last_len = ((fill_count_reg != '0) && (rd_data_reg == CH_RETURN)) ?
                      fill_minus : fill_count_reg;

    always_comb
    begin
        state_next = state_reg;
        fill_count_next = fill_count_reg;
        discarding_next = discarding_reg;
        len_next = len_reg;
        cmp_pos_next = cmp_pos_reg;
        done_status_next = done_status_reg;
        done_cmp_next = done_cmp_reg;
        out_valid_next = out_valid_reg & out_stall;
        line_status_next = line_status_reg;
        display_state_next = display_state_reg;
        wr_en = 1'b0;
        rd_addr = fill_minus[ADDR_W-1:0];
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (rx_byte != CH_NEWLINE)
                    begin
                        if (!discarding_reg)
                        begin
                            if (int'(fill_count_reg) >= LINE_CAPACITY)
                            begin
                                fill_count_next = '0;
                                discarding_next = 1'b1;
                            end
                            else
                            begin
                                wr_en = 1'b1;
                                fill_count_next = fill_count_reg + FILL_W'(1);
                            end
                        end
                    end
                    else if (discarding_reg)
                    begin
                        discarding_next = 1'b0;
                        done_status_next = STATUS_OVERSIZED;
                        done_cmp_next = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_LAST;
                    end
                end
            end
            S_LAST:
            begin
                rd_addr = '0;
                fill_count_next = '0;
                len_next = last_len;
                cmp_pos_next = '0;
                if (len_legal(last_len))
                begin
                    cmd.clear = 1'b1;
                    done_cmp_next = 1'b1;
                    state_next = S_CMP;
                end
                else
                begin
                    done_status_next = STATUS_MALFORMED;
                    done_cmp_next = 1'b0;
                    state_next = S_DONE;
                end
            end
            S_CMP:
            begin
                rd_addr = ADDR_W'(cmp_pos_reg + 1'b1);
                cmd.step = 1'b1;
                cmp_pos_next = ADDR_W'(cmp_pos_reg + 1'b1);
                if ({1'b0, cmp_pos_reg} == FILL_W'(len_reg - FILL_W'(1)))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    if (done_cmp_reg && res.matched)
                    begin
                        line_status_next = STATUS_VALID;
                        display_state_next = res.code;
                    end
                    else
                    begin
                        line_status_next = done_cmp_reg ? STATUS_MALFORMED : done_status_reg;
                        display_state_next = 3'd0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[fill_count_reg[ADDR_W-1:0]] <= rx_byte;
        end
        rd_data_reg <= line_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_count_reg <= '0;
            discarding_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_count_reg <= fill_count_next;
            discarding_reg <= discarding_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        cmp_pos_reg <= cmp_pos_next;
        done_status_reg <= done_status_next;
        done_cmp_reg <= done_cmp_next;
        line_status_reg <= line_status_next;
        display_state_reg <= display_state_next;
    end

    slr_matcher u_matcher (
        .clk  (clk),
        .cmd  (cmd),
        .len  (last_len),
        .pos  (cmp_pos_reg),
        .data (rd_data_reg),
        .res  (res)
    );

    assign out_valid = out_valid_reg;
    assign line_status = line_status_reg;
    assign display_state = display_state_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(fill_count_reg) <= LINE_CAPACITY)
        else $error("fill count beyond line capacity");

    a_discard_empty: assert property (@(posedge clk) disable iff (!rst_n)
        discarding_reg |-> (fill_count_reg == '0))
        else $error("bytes stored while discarding");

    a_cmp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> ({1'b0, cmp_pos_reg} < len_reg))
        else $error("compare position past line length");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside the done step");

    a_state_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (display_state_reg != 3'd0)) |-> (line_status_reg == STATUS_VALID))
        else $error("state code on a non-valid line");

endmodule

// ----- dv/state_line_checker.sv -----
// Checker for the state line receiver: watches both channels, predicts the
// verdict of every completed line and compares it with each result word.
// Depends on slr_pkg for the line capacity, character and status codes.
`timescale 1ns / 100ps

module state_line_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] rx_byte,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [1:0] line_status,
    input  logic [2:0] display_state,
    input  logic       out_valid,
    input  logic       out_stall,
    output int         mismatches,
    output int         awaiting,
    output int         lines_done,
    output int         valid_lines,
    output int         oversized_lines
);
    import slr_pkg::*;

    typedef enum logic [2:0] {
        DS_STARTING,
        DS_READY,
        DS_LINK_PENDING,
        DS_LINK_UP,
        DS_FAULT,
        DS_OFF
    } panel_state_t;

    typedef struct packed {
        logic [1:0]   status;
        panel_state_t state;
    } verdict_t;

    string prefix = "PANEL 1 STATE ";
    string words [6] = '{"starting", "ready", "hotspot_waiting", "hotspot_connected",
                         "fault", "off"};

    logic [7:0] line_buf [LINE_CAPACITY];
    int         fill;
    bit         skipping;
    verdict_t   verdict_q [$];
    verdict_t   oldest;

    function automatic bit text_at(input int start, input string s);
        bit same;
        same = 1'b1;
        for (int i = 0; i < s.len(); i++)
        begin
            if (start + i >= LINE_CAPACITY || line_buf[start + i] != s[i])
            begin
                same = 1'b0;
            end
        end
        return same;
    endfunction

    function automatic verdict_t judge_line(input int len);
        verdict_t v;
        int rest;
        v.status = STATUS_MALFORMED;
        v.state = DS_STARTING;
        if (len > prefix.len() && text_at(0, prefix))
        begin
            rest = len - prefix.len();
            for (int w = 0; w < 6; w++)
            begin
                if (rest == words[w].len() && text_at(prefix.len(), words[w]))
                begin
                    v.status = STATUS_VALID;
                    v.state = panel_state_t'(w);
                end
            end
        end
        return v;
    endfunction

    task automatic take_byte(input logic [7:0] ch);
        int len;
        verdict_t v;
        if (ch != CH_NEWLINE)
        begin
            if (!skipping)
            begin
                if (fill >= LINE_CAPACITY)
                begin
                    fill = 0;
                    skipping = 1'b1;
                end
                else
                begin
                    line_buf[fill] = ch;
                    fill++;
                end
            end
        end
        else
        begin
            if (skipping)
            begin
                skipping = 1'b0;
                v.status = STATUS_OVERSIZED;
                v.state = DS_STARTING;
            end
            else
            begin
                len = fill;
                if (len > 0 && line_buf[len - 1] == CH_RETURN)
                begin
                    len--;
                end
                v = judge_line(len);
                fill = 0;
            end
            verdict_q.push_back(v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill = 0;
            skipping = 1'b0;
            verdict_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("Unexpected result word: line_status %0d, display_state %0d",
                           line_status, display_state);
                    mismatches++;
                end
                else
                begin
                    oldest = verdict_q.pop_front();
                    if (line_status !== oldest.status)
                    begin
                        $error("line_status: expected %0d, actual %0d",
                               oldest.status, line_status);
                        mismatches++;
                    end
                    if (display_state !== oldest.state)
                    begin
                        $error("display_state: expected %0d, actual %0d",
                               oldest.state, display_state);
                        mismatches++;
                    end
                    lines_done++;
                    if (oldest.status == STATUS_VALID)
                    begin
                        valid_lines++;
                    end
                    if (oldest.status == STATUS_OVERSIZED)
                    begin
                        oversized_lines++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                take_byte(rx_byte);
            end
        end
        awaiting = verdict_q.size();
    end

endmodule

// ----- dv/state_line_receiver_unit_tb.sv -----
// Testbench top for the state line receiver: drives received bytes as whole
// lines under several idle and stall mixes and gives the verdict.
// Depends on slr_pkg, state_line_receiver_unit and state_line_checker.
`timescale 1ns / 100ps

module state_line_receiver_unit_tb;
    import slr_pkg::*;

    typedef logic [7:0] text_t [$];

    logic       clk;
    logic       rst_n;
    logic [7:0] rx_byte;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] line_status;
    logic [2:0] display_state;
    logic       out_valid;
    logic       out_stall;

    int mismatches;
    int awaiting;
    int lines_done;
    int valid_lines;
    int oversized_lines;
    int send_idle_pct;
    int recv_stall_pct;
    int bytes_sent;

    state_line_receiver_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .rx_byte(rx_byte),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .line_status(line_status),
        .display_state(display_state),
        .out_valid(out_valid),
        .out_stall(out_stall)
    );

    state_line_checker checker_inst (
        .clk(clk),
        .rst_n(rst_n),
        .rx_byte(rx_byte),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .line_status(line_status),
        .display_state(display_state),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .mismatches(mismatches),
        .awaiting(awaiting),
        .lines_done(lines_done),
        .valid_lines(valid_lines),
        .oversized_lines(oversized_lines)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            rx_byte <= 8'($urandom);
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_line(input text_t t);
        foreach (t[i])
        begin
            send_byte(t[i]);
        end
        send_byte(CH_NEWLINE);
    endtask

    function automatic text_t state_text(input int w, input bit with_cr);
        text_t t;
        for (int i = 0; i < HEAD_LEN; i++)
        begin
            t.push_back(head_char(ADDR_W'(i)));
        end
        for (int i = 0; i < WORD_LEN[w]; i++)
        begin
            t.push_back(word_char(w, i));
        end
        if (with_cr)
        begin
            t.push_back(CH_RETURN);
        end
        return t;
    endfunction

    function automatic text_t noise_text(input int n);
        text_t t;
        logic [7:0] b;
        for (int i = 0; i < n; i++)
        begin
            do
                b = 8'($urandom);
            while (b == CH_NEWLINE);
            t.push_back(b);
        end
        return t;
    endfunction

    task automatic random_line();
        int kind;
        int pos;
        int w;
        text_t t;
        kind = $urandom_range(99);
        w = $urandom_range(5);
        if (kind < 50)
        begin
            t = state_text(w, 1'($urandom_range(1)));
        end
        else if (kind < 70)
        begin
            t = state_text(w, 1'b0);
            pos = $urandom_range(t.size() - 1);
            case ($urandom_range(4))
                0: t[pos] ^= 8'(1 << $urandom_range(7));
                1: void'(t.pop_back());
                2: t.push_back(8'($urandom_range(32, 126)));
                3: t.insert(pos, CH_RETURN);
                default:
                begin
                    t.push_back(CH_RETURN);
                    t.push_back(CH_RETURN);
                end
            endcase
        end
        else if (kind < 85)
        begin
            t = noise_text($urandom_range(20));
        end
        else if (kind < 92)
        begin
            t = state_text(w, 1'($urandom_range(1)));
            for (int i = HEAD_LEN; i < HEAD_LEN + WORD_LEN[w]; i++)
            begin
                t[i] = 8'($urandom_range(97, 122));
            end
        end
        else if (kind < 97)
        begin
            t = noise_text($urandom_range(LINE_CAPACITY + 1, LINE_CAPACITY + 24));
        end
        else
        begin
            t = noise_text($urandom_range(LINE_CAPACITY - 2, LINE_CAPACITY));
            if ($urandom_range(1))
            begin
                t.push_back(CH_RETURN);
            end
        end
        send_line(t);
    endtask

    task automatic run_phase(input int idle, input int stall, input int quota);
        int target;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        target = bytes_sent + quota;
        while (bytes_sent < target)
        begin
            random_line();
        end
    endtask

    task automatic directed_lines();
        text_t t;
        for (int w = 0; w < WORD_COUNT; w++)
        begin
            send_line(state_text(w, 1'(w % 2)));
        end
        t.delete();
        send_line(t);
        t.push_back(CH_RETURN);
        send_line(t);
        t = state_text(1, 1'b1);
        t.push_back(CH_RETURN);
        send_line(t);
        t = state_text(0, 1'b0);
        t = t[0:HEAD_LEN - 1];
        send_line(t);
        t = state_text(4, 1'b0);
        t[HEAD_LEN] = "F";
        send_line(t);
        t.delete();
        t.push_back(8'h00);
        t.push_back(8'hFF);
        send_line(t);
        send_line(noise_text(LINE_CAPACITY));
        t = noise_text(LINE_CAPACITY - 1);
        t.push_back(CH_RETURN);
        send_line(t);
        t = noise_text(LINE_CAPACITY);
        t.push_back(CH_RETURN);
        send_line(t);
        send_line(noise_text(LINE_CAPACITY + 1));
        send_line(state_text(3, 1'b0));
        t.delete();
        for (int i = 0; i < 3 * LINE_CAPACITY; i++)
        begin
            t.push_back(8'hFF);
        end
        send_line(t);
        t = state_text(5, 1'b0);
        t.insert(HEAD_LEN, CH_RETURN);
        send_line(t);
        t = state_text(2, 1'b0);
        t.push_back(" ");
        send_line(t);
    endtask

    initial
    begin
        int waited;
        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = 8'd0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        bytes_sent = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed_lines();
        run_phase(0, 0, 260);
        run_phase(86, 0, 260);
        run_phase(0, 86, 260);
        run_phase(23, 23, 260);
        in_valid <= 1'b0;

        waited = 0;
        while (awaiting != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (60) @(posedge clk);
        if (awaiting != 0)
        begin
            $error("%0d line results never arrived", awaiting);
        end

        $display("Sent %0d bytes; %0d lines checked, %0d of them valid state lines,",
                 bytes_sent, lines_done, valid_lines);
        $display("%0d oversized, across free-running, idle-heavy, stall-heavy and mixed traffic.",
                 oversized_lines);
        if (mismatches == 0 && awaiting == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- state_line_receiver_unit.f -----
src/slr_pkg.sv
src/slr_matcher.sv
src/state_line_receiver_unit.sv
dv/state_line_checker.sv
dv/state_line_receiver_unit_tb.sv
